### rtl/tmssd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tmssd_pkg;

  // image geometry
  localparam int IMAGE_WIDTH  = 128;
  localparam int IMAGE_HEIGHT = 128;
  localparam int PIXEL_COUNT  = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int ROW_W        = 7;
  localparam int COL_W        = 7;
  localparam int PIX_ADDR_W   = ROW_W + COL_W;
  localparam int PIX_W        = 24;
  localparam int CHAN_W       = 8;
  localparam int SCORE_W      = 8;
  localparam int FRAG_DIM_W   = 8;

  localparam logic [SCORE_W-1:0] SCORE_MAX = 8'd255;

  // beat modes
  localparam logic [1:0] MODE_BASE_WR = 2'd0;
  localparam logic [1:0] MODE_FRAG_WR = 2'd1;
  localparam logic [1:0] MODE_QUERY   = 2'd2;

  // configuration register indexes
  localparam int          CFG_INDEX_W     = 2;
  localparam logic [1:0]  REG_FRAG_WIDTH  = 2'd0;
  localparam logic [1:0]  REG_FRAG_HEIGHT = 2'd1;
  localparam int          CFG_DATA_W      = 8;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } in_beat_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [ROW_W-1:0]   score_row;
    logic [COL_W-1:0]   score_col;
  } out_beat_t;

  // control travelling alongside the memory read data
  typedef struct packed {
    logic valid;
    logic last;
  } cost_ctrl_t;

endpackage
`default_nettype wire

### rtl/tmssd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module tmssd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### rtl/tmssd_cost.sv
`timescale 1ns / 1ps
`default_nettype none
module tmssd_cost (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          clear,
  input  wire tmssd_pkg::cost_ctrl_t         ctrl,
  input  wire logic [tmssd_pkg::PIX_W-1:0]   base_pix,
  input  wire logic [tmssd_pkg::PIX_W-1:0]   frag_pix,
  output logic                               done_r,
  output logic [tmssd_pkg::SCORE_W-1:0]      score
);
  import tmssd_pkg::*;

  logic [CHAN_W-1:0]   d_red, d_green, d_blue;
  logic [2*CHAN_W-1:0] sq_red_r, sq_green_r, sq_blue_r;
  cost_ctrl_t          sq_ctrl_r;
  logic [SCORE_W-1:0]  acc_r;
  logic                sat_r;
  logic [2*CHAN_W+2:0] total;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
    abs_diff = (a > b) ? a - b : b - a;
  endfunction

  // absolute channel differences
  always_comb begin
    d_red   = abs_diff(base_pix[23:16], frag_pix[23:16]);
    d_green = abs_diff(base_pix[15:8],  frag_pix[15:8]);
    d_blue  = abs_diff(base_pix[7:0],   frag_pix[7:0]);
  end

  // squaring stage
  always_ff @(posedge clk) begin
    sq_red_r   <= (2*CHAN_W)'(d_red) * (2*CHAN_W)'(d_red);
    sq_green_r <= (2*CHAN_W)'(d_green) * (2*CHAN_W)'(d_green);
    sq_blue_r  <= (2*CHAN_W)'(d_blue) * (2*CHAN_W)'(d_blue);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_ctrl_r <= '0;
    end else begin
      sq_ctrl_r <= ctrl;
    end
  end

  // pixel cost plus running sum
  assign total = {3'b000, sq_red_r} + {3'b000, sq_green_r} + {3'b000, sq_blue_r}
               + {{(2*CHAN_W+3-SCORE_W){1'b0}}, acc_r};

  // saturating accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      sat_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= sq_ctrl_r.valid && sq_ctrl_r.last;
      if (clear) begin
        acc_r <= '0;
        sat_r <= 1'b0;
      end else if (sq_ctrl_r.valid) begin
        acc_r <= total[SCORE_W-1:0];
        if (total > {{(2*CHAN_W+3-SCORE_W){1'b0}}, SCORE_MAX}) begin
          sat_r <= 1'b1;
        end
      end
    end
  end

  assign score = sat_r ? SCORE_MAX : acc_r;

endmodule
`default_nettype wire

### rtl/template_match_ssd_map_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Template match unit: sum of squared RGB differences, saturated at 255.
// Input channel (in_valid / in_stall / in_data): each beat is a base pixel
// write, a fragment pixel write or a score query at (row, col). Writes give
// no result. A query sweeps the fragment one pixel per cycle, reading the
// base and fragment memories side by side. Overhanging positions and empty
// fragments answer without a sweep. One beat is worked on at a time:
// in_stall is high while a query is in progress.
// Result channel (out_valid / out_stall / out_data): one beat per query
// carrying score and the queried row and column. A result waits in the
// output register while out_stall is high; the unit keeps accepting writes
// and starts the next query meanwhile, and holds that query's result until
// the output register frees up.
// Configuration (cfg_we / cfg_index / cfg_wdata): fragment width at index 0
// and height at index 1, to be written only while the unit is idle; the
// unit itself does not enforce this.
// Reset sets the fragment to 16 by 16 and empties the result channel; the
// image memories are not cleared and must be written before they are read.
module template_match_ssd_map_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire tmssd_pkg::in_beat_t               in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output tmssd_pkg::out_beat_t                   out_data,
  input  wire logic                              cfg_we,
  input  wire logic [tmssd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tmssd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tmssd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [FRAG_DIM_W-1:0] frag_w_r, frag_h_r;
  logic [ROW_W-1:0]      row_r, r_r, fh_m1_r;
  logic [COL_W-1:0]      col_r, c_r, fw_m1_r;
  logic [SCORE_W-1:0]    res_score_r;
  cost_ctrl_t            rd_ctrl_r, issue_ctrl;
  logic                  out_valid_r;
  out_beat_t             out_data_r;

  logic                  in_acc, is_query, overhang, empty_frag, cost_clear;
  logic                  out_load, cost_done;
  logic [FRAG_DIM_W:0]   row_end, col_end;
  logic [ROW_W-1:0]      win_row;
  logic [COL_W-1:0]      win_col;
  logic [PIX_W-1:0]      wr_pix, base_pix, frag_pix;
  logic [SCORE_W-1:0]    cost_score;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign is_query = (in_data.mode == MODE_QUERY);
  assign wr_pix   = {in_data.red, in_data.green, in_data.blue};

  // overhang and empty fragment checks at query time
  assign row_end    = {2'b00, in_data.row} + {1'b0, frag_h_r};
  assign col_end    = {2'b00, in_data.col} + {1'b0, frag_w_r};
  assign overhang   = (row_end > (FRAG_DIM_W+1)'(IMAGE_HEIGHT))
                   || (col_end > (FRAG_DIM_W+1)'(IMAGE_WIDTH));
  assign empty_frag = (frag_w_r == '0) || (frag_h_r == '0);
  assign cost_clear = in_acc && is_query;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frag_w_r <= 8'd16;
      frag_h_r <= 8'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAG_WIDTH:  frag_w_r <= cfg_wdata;
        REG_FRAG_HEIGHT: frag_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sweep issue control
  always_comb begin
    issue_ctrl.valid = (state_r == S_RUN);
    issue_ctrl.last  = (r_r == fh_m1_r) && (c_r == fw_m1_r);
  end

  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && is_query) begin
          state_nxt = (overhang || empty_frag) ? S_DONE : S_RUN;
        end
      end
      S_RUN: begin
        if (issue_ctrl.last) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (cost_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rd_ctrl_r <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_ctrl_r <= issue_ctrl;
    end
  end

  // query context, sweep counters and held result
  always_ff @(posedge clk) begin
    if (in_acc && is_query) begin
      row_r   <= in_data.row;
      col_r   <= in_data.col;
      fh_m1_r <= ROW_W'(frag_h_r - 8'd1);
      fw_m1_r <= COL_W'(frag_w_r - 8'd1);
      r_r     <= '0;
      c_r     <= '0;
      if (overhang) begin
        res_score_r <= SCORE_MAX;
      end else begin
        res_score_r <= '0;
      end
    end else if (state_r == S_RUN) begin
      if (c_r == fw_m1_r) begin
        c_r <= '0;
        r_r <= r_r + ROW_W'(1);
      end else begin
        c_r <= c_r + COL_W'(1);
      end
    end else if (state_r == S_WAIT && cost_done) begin
      res_score_r <= cost_score;
    end
  end

  assign win_row = row_r + r_r;
  assign win_col = col_r + c_r;

  // image memories
  tmssd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (PIXEL_COUNT)
  ) u_base_ram (
    .clk       (clk),
    .wr_en     (in_acc && (in_data.mode == MODE_BASE_WR)),
    .wr_addr   ({in_data.row, in_data.col}),
    .wr_data   (wr_pix),
    .rd_en     (issue_ctrl.valid),
    .rd_addr   ({win_row, win_col}),
    .rd_data_r (base_pix)
  );

  tmssd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (PIXEL_COUNT)
  ) u_frag_ram (
    .clk       (clk),
    .wr_en     (in_acc && (in_data.mode == MODE_FRAG_WR)),
    .wr_addr   ({in_data.row, in_data.col}),
    .wr_data   (wr_pix),
    .rd_en     (issue_ctrl.valid),
    .rd_addr   ({r_r, c_r}),
    .rd_data_r (frag_pix)
  );

  // squared difference accumulator
  tmssd_cost u_cost (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (cost_clear),
    .ctrl     (rd_ctrl_r),
    .base_pix (base_pix),
    .frag_pix (frag_pix),
    .done_r   (cost_done),
    .score    (cost_score)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.score     <= res_score_r;
      out_data_r.score_row <= row_r;
      out_data_r.score_col <= col_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

### verif/template_match_ssd_map_unit_tb.sv
`timescale 1ns / 1ps
module template_match_ssd_map_unit_tb;
  import tmssd_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 10;
  localparam int END_CYCLES    = 40;
  localparam int LONG_HOLD     = 600;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // beats waiting to be offered and scores waiting to come back
  in_beat_t  beats_to_send [$];
  out_beat_t expected_scores [$];
  int        beats_queued = 0;
  int        beats_accepted = 0;
  bit        in_fire = 1'b0;
  int        mismatch_cnt = 0;
  int        cycle_cnt = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_off_left = 0;

  // image contents as seen at the block's input
  logic [PIX_W-1:0]      base_pix_model [PIXEL_COUNT];
  logic [PIX_W-1:0]      frag_pix_model [PIXEL_COUNT];
  logic [FRAG_DIM_W-1:0] frag_w_model = 8'd16;
  logic [FRAG_DIM_W-1:0] frag_h_model = 8'd16;

  // what the stimulus has already queued, so no query reads an unwritten pixel
  bit               base_written [PIXEL_COUNT];
  bit               frag_written [PIXEL_COUNT];
  logic [PIX_W-1:0] frag_pix_planned [PIXEL_COUNT];
  int               gen_fw = 16;
  int               gen_fh = 16;

  template_match_ssd_map_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // saturated sum of squared colour differences at a base position
  function automatic logic [SCORE_W-1:0] match_score_of(logic [ROW_W-1:0] r,
                                                        logic [COL_W-1:0] c);
    int unsigned acc;
    int i, j, k, d;
    logic [PIX_W-1:0] bp, fp;
    if (frag_h_model > IMAGE_HEIGHT || frag_w_model > IMAGE_WIDTH) return SCORE_MAX;
    if (int'(r) + int'(frag_h_model) > IMAGE_HEIGHT ||
        int'(c) + int'(frag_w_model) > IMAGE_WIDTH) return SCORE_MAX;
    acc = 0;
    for (i = 0; i < int'(frag_h_model); i++) begin
      for (j = 0; j < int'(frag_w_model); j++) begin
        bp = base_pix_model[(int'(r) + i) * IMAGE_WIDTH + int'(c) + j];
        fp = frag_pix_model[i * IMAGE_WIDTH + j];
        for (k = 0; k < 3; k++) begin
          d = int'(bp[CHAN_W*k +: CHAN_W]) - int'(fp[CHAN_W*k +: CHAN_W]);
          acc += d * d;
        end
        if (acc > SCORE_MAX) return SCORE_MAX;
      end
    end
    return acc[SCORE_W-1:0];
  endfunction

  task automatic track_beat(in_beat_t b);
    int idx;
    out_beat_t res;
    idx = int'(b.row) * IMAGE_WIDTH + int'(b.col);
    case (b.mode)
      MODE_BASE_WR: begin
        base_pix_model[idx] = {b.red, b.green, b.blue};
      end
      MODE_FRAG_WR: begin
        frag_pix_model[idx] = {b.red, b.green, b.blue};
      end
      MODE_QUERY: begin
        res.score     = match_score_of(b.row, b.col);
        res.score_row = b.row;
        res.score_col = b.col;
        expected_scores.push_back(res);
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(string what, out_beat_t exp_b, out_beat_t got_b);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("mismatch (%s): expected score %0d row %0d col %0d, got score %0d row %0d col %0d",
               what, exp_b.score, exp_b.score_row, exp_b.score_col,
               got_b.score, got_b.score_row, got_b.score_col);
  endtask

  // sample both channels and the register port at the rising edge
  always @(posedge clk) begin : monitor
    out_beat_t exp_beat;
    in_fire = 1'b0;
    if (!rst_n) begin
      frag_w_model = 8'd16;
      frag_h_model = 8'd16;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAG_WIDTH:  frag_w_model = cfg_wdata;
          REG_FRAG_HEIGHT: frag_h_model = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        in_fire = 1'b1;
        beats_accepted++;
        track_beat(in_data);
      end
      if (out_valid && !out_stall) begin
        if (expected_scores.size() == 0) begin
          note_mismatch("result with none expected", '0, out_data);
        end else begin
          exp_beat = expected_scores.pop_front();
          if (out_data.score !== exp_beat.score ||
              out_data.score_row !== exp_beat.score_row ||
              out_data.score_col !== exp_beat.score_col)
            note_mismatch("wrong field", exp_beat, out_data);
        end
      end
    end
  end

  // sender: next beat at the falling edge, one assignment per signal
  always @(negedge clk) begin : sender
    logic     nxt_valid;
    in_beat_t nxt_data;
    nxt_valid = in_valid;
    nxt_data  = in_data;
    if (in_fire) nxt_valid = 1'b0;
    if (rst_n && !nxt_valid && beats_to_send.size() != 0 &&
        int'($urandom_range(99)) >= send_idle_pct) begin
      nxt_data  = beats_to_send.pop_front();
      nxt_valid = 1'b1;
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_data;
  end

  // receiver: random stalls, or a long hold-off counted down here
  always @(negedge clk) begin : receiver
    if (hold_off_left != 0) begin
      out_stall     <= 1'b1;
      hold_off_left <= hold_off_left - 1;
    end else begin
      out_stall <= (int'($urandom_range(99)) < recv_stall_pct);
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("** template_match_ssd_map_unit: FAILED **");
    $finish;
  end

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_FRAG_WIDTH) gen_fw = int'(val);
    else if (idx == REG_FRAG_HEIGHT) gen_fh = int'(val);
  endtask

  task automatic push_beat(logic [1:0] mode, int r, int c, logic [PIX_W-1:0] pix);
    in_beat_t b;
    int idx;
    b.mode  = mode;
    b.row   = ROW_W'(r);
    b.col   = COL_W'(c);
    b.red   = pix[23:16];
    b.green = pix[15:8];
    b.blue  = pix[7:0];
    idx = r * IMAGE_WIDTH + c;
    if (mode == MODE_BASE_WR) begin
      base_written[idx] = 1'b1;
    end else if (mode == MODE_FRAG_WR) begin
      frag_written[idx]     = 1'b1;
      frag_pix_planned[idx] = pix;
    end
    beats_to_send.push_back(b);
    beats_queued++;
  endtask

  // wait until every beat went in and every score came back
  task automatic settle();
    @(negedge clk);
    while (beats_accepted != beats_queued || expected_scores.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // pixel close to p, each channel moved by up to spread, or fully random
  function automatic logic [PIX_W-1:0] near_pixel(logic [PIX_W-1:0] p, int spread,
                                                  int wild_pct);
    logic [PIX_W-1:0] q;
    int k, v;
    if (int'($urandom_range(99)) < wild_pct) return PIX_W'($urandom);
    for (k = 0; k < 3; k++) begin
      v = int'(p[CHAN_W*k +: CHAN_W]) + int'($urandom_range(2 * spread)) - spread;
      if (v < 0) v = 0;
      else if (v > 255) v = 255;
      q[CHAN_W*k +: CHAN_W] = CHAN_W'(v);
    end
    return q;
  endfunction

  // overhanging and empty queries read nothing; others need a written window
  function automatic bit query_safe(int r, int c);
    int i, j;
    if (gen_fh == 0 || gen_fw == 0) return 1'b1;
    if (r + gen_fh > IMAGE_HEIGHT || c + gen_fw > IMAGE_WIDTH) return 1'b1;
    for (i = 0; i < gen_fh; i++)
      for (j = 0; j < gen_fw; j++)
        if (!base_written[(r + i) * IMAGE_WIDTH + c + j] ||
            !frag_written[i * IMAGE_WIDTH + j]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic write_fragment();
    int i, j;
    for (i = 0; i < gen_fh; i++)
      for (j = 0; j < gen_fw; j++)
        push_beat(MODE_FRAG_WR, i, j, PIX_W'($urandom));
  endtask

  // base window resembling the fragment, then a query on it and sometimes one beside it
  task automatic match_sequence();
    int r, c, i, j, spread, r2, c2;
    r = $urandom_range(IMAGE_HEIGHT - gen_fh);
    c = $urandom_range(IMAGE_WIDTH - gen_fw);
    spread = $urandom_range(2);
    for (i = 0; i < gen_fh; i++)
      for (j = 0; j < gen_fw; j++)
        push_beat(MODE_BASE_WR, r + i, c + j,
                  near_pixel(frag_pix_planned[i * IMAGE_WIDTH + j], spread, 10));
    push_beat(MODE_QUERY, r, c, PIX_W'($urandom));
    if ($urandom_range(99) < 30) begin
      r2 = r + int'($urandom_range(2)) - 1;
      c2 = c + int'($urandom_range(2)) - 1;
      if (r2 >= 0 && r2 < IMAGE_HEIGHT && c2 >= 0 && c2 < IMAGE_WIDTH &&
          query_safe(r2, c2))
        push_beat(MODE_QUERY, r2, c2, PIX_W'($urandom));
    end
  endtask

  task automatic noise_beat();
    int pick, r, c;
    pick = $urandom_range(99);
    r = $urandom_range(IMAGE_HEIGHT - 1);
    c = $urandom_range(IMAGE_WIDTH - 1);
    if (pick < 45) begin
      push_beat(MODE_BASE_WR, r, c, PIX_W'($urandom));
    end else if (pick < 65) begin
      push_beat(MODE_FRAG_WR, r, c, PIX_W'($urandom));
    end else if (pick < 80) begin
      push_beat(MODE_UNUSED, r, c, PIX_W'($urandom));
    end else begin
      // lean towards the bottom and right edges where the fragment overhangs
      if ($urandom_range(1) == 1) r = $urandom_range(IMAGE_HEIGHT - 1, IMAGE_HEIGHT - 8);
      if ($urandom_range(1) == 1) c = $urandom_range(IMAGE_WIDTH - 1, IMAGE_WIDTH - 8);
      if (query_safe(r, c)) push_beat(MODE_QUERY, r, c, PIX_W'($urandom));
    end
  endtask

  task automatic run_small_phase(int fw, int fh, int n_beats, int idle_s, int idle_r,
                                 bit long_hold);
    int goal, half;
    bit paused;
    write_reg(REG_FRAG_WIDTH, CFG_DATA_W'(fw));
    write_reg(REG_FRAG_HEIGHT, CFG_DATA_W'(fh));
    send_idle_pct  = idle_s;
    recv_stall_pct = idle_r;
    if (long_hold) begin
      @(posedge clk);
      hold_off_left = LONG_HOLD;
    end
    goal   = beats_queued + n_beats;
    half   = beats_queued + n_beats / 2;
    paused = 1'b0;
    write_fragment();
    while (beats_queued < goal) begin
      // stimulus stops queueing midway until every beat is in and every score is back
      if (!paused && beats_queued >= half) begin
        settle();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 60) match_sequence();
      else noise_beat();
    end
    settle();
  endtask

  initial begin : stimulus
    int r, j;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // unknown register indexes leave the 16 by 16 default in place
    write_reg(REG_SPARE_A, 8'hA5);
    write_reg(REG_SPARE_B, 8'h5A);
    push_beat(MODE_BASE_WR, 0, 0, 24'h000000);
    push_beat(MODE_BASE_WR, 127, 127, 24'hFFFFFF);
    push_beat(MODE_BASE_WR, 0, 127, 24'hFF00FF);
    push_beat(MODE_BASE_WR, 127, 0, 24'h00FF00);
    push_beat(MODE_FRAG_WR, 0, 0, 24'hFFFFFF);
    push_beat(MODE_FRAG_WR, 127, 127, 24'h000000);
    push_beat(MODE_UNUSED, 127, 127, 24'hFFFFFF);
    push_beat(MODE_UNUSED, 0, 0, 24'h000000);
    push_beat(MODE_QUERY, 113, 0, 24'h000000);
    push_beat(MODE_QUERY, 0, 113, 24'hFFFFFF);
    push_beat(MODE_QUERY, 127, 127, 24'h000000);
    push_beat(MODE_QUERY, 120, 64, 24'h000000);
    settle();

    // empty fragment, full image height
    write_reg(REG_FRAG_WIDTH, 8'd0);
    write_reg(REG_FRAG_HEIGHT, 8'd128);
    push_beat(MODE_QUERY, 0, 0, 24'h000000);
    push_beat(MODE_QUERY, 0, 127, 24'h000000);
    push_beat(MODE_QUERY, 1, 5, 24'h000000);
    push_beat(MODE_QUERY, 127, 127, 24'h000000);
    settle();

    // zero height
    write_reg(REG_FRAG_WIDTH, 8'd7);
    write_reg(REG_FRAG_HEIGHT, 8'd0);
    push_beat(MODE_QUERY, 127, 121, 24'h000000);
    push_beat(MODE_QUERY, 127, 122, 24'h000000);
    settle();

    // fragment larger than the image
    write_reg(REG_FRAG_WIDTH, 8'd255);
    write_reg(REG_FRAG_HEIGHT, 8'd255);
    push_beat(MODE_QUERY, 0, 0, 24'h000000);
    push_beat(MODE_QUERY, 64, 64, 24'h000000);
    settle();
    write_reg(REG_FRAG_WIDTH, 8'd129);
    write_reg(REG_FRAG_HEIGHT, 8'd1);
    push_beat(MODE_QUERY, 0, 0, 24'h000000);
    settle();

    // one full-width fragment row against a nearly identical base row
    write_reg(REG_FRAG_WIDTH, 8'd128);
    write_reg(REG_FRAG_HEIGHT, 8'd1);
    send_idle_pct  = 33;
    recv_stall_pct = 33;
    for (j = 0; j < IMAGE_WIDTH; j++) push_beat(MODE_FRAG_WR, 0, j, PIX_W'($urandom));
    r = $urandom_range(IMAGE_HEIGHT - 1);
    for (j = 0; j < IMAGE_WIDTH; j++)
      push_beat(MODE_BASE_WR, r, j,
                near_pixel(frag_pix_planned[j], ($urandom_range(99) < 15) ? 1 : 0, 0));
    push_beat(MODE_QUERY, r, 0, PIX_W'($urandom));
    push_beat(MODE_QUERY, r, $urandom_range(IMAGE_WIDTH - 1, 1), PIX_W'($urandom));
    j = $urandom_range(IMAGE_HEIGHT - 1);
    if (query_safe(j, 0)) push_beat(MODE_QUERY, j, 0, PIX_W'($urandom));
    for (j = 0; j < 3; j++)
      push_beat(MODE_BASE_WR, r, $urandom_range(IMAGE_WIDTH - 1), PIX_W'($urandom));
    push_beat(MODE_QUERY, r, 0, PIX_W'($urandom));
    settle();

    // small fragments with the idling mixes
    run_small_phase(1, 1, 110, 0, 0, 1'b0);
    run_small_phase($urandom_range(4, 1), $urandom_range(4, 1), 120, 73, 0, 1'b0);
    run_small_phase($urandom_range(4, 1), $urandom_range(4, 1), 120, 0, 73, 1'b1);
    run_small_phase($urandom_range(4, 1), $urandom_range(4, 1), 120, 33, 33, 1'b0);
    run_small_phase(8, 2, 110, 0, 0, 1'b0);

    repeat (END_CYCLES) @(negedge clk);
    if (mismatch_cnt == 0 && expected_scores.size() == 0) begin
      $display("** template_match_ssd_map_unit: PASSED **");
    end else begin
      $display("** template_match_ssd_map_unit: FAILED **");
    end
    $finish;
  end

endmodule
